// File: rtl/core/crc32_two_mode_byte_stream_core_assert.svh
// ----------------------------------------------------------------------------
// CRC-32 byte stream core assertion macros
// Shared property wrappers clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CRC32_TWO_MODE_BYTE_STREAM_CORE_ASSERT_SVH
`define CRC32_TWO_MODE_BYTE_STREAM_CORE_ASSERT_SVH

// same-cycle implication
`define CRC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crc32 core assertion failed");

// next-cycle implication
`define CRC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crc32 core assertion failed");

`endif

// File: rtl/core/crc32tm_pkg.sv
// ----------------------------------------------------------------------------
// CRC-32 two-mode package
// Register codes, reset constants and the bit-level fold and reflect helpers.
// ----------------------------------------------------------------------------
package crc32tm_pkg;

	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ETH_MODE = 2'd0,
		CFG_POLY     = 2'd1
	} cfg_idx_t;

	typedef logic [31:0] crc_t;
	typedef logic [7:0]  byte_t;

	localparam crc_t CRC_PRESET   = 32'hFFFF_FFFF;
	localparam crc_t DEFAULT_POLY = 32'h04C1_1DB7;

	function automatic byte_t flip8(input byte_t b);
		byte_t r;
		for (int i = 0; i < 8; i++) begin
			r[i] = b[7-i];
		end
		return r;
	endfunction

	function automatic crc_t flip32(input crc_t w);
		crc_t r;
		for (int i = 0; i < 32; i++) begin
			r[i] = w[31-i];
		end
		return r;
	endfunction

	function automatic crc_t fold8(input crc_t crc, input byte_t b, input crc_t poly);
		crc_t c;
		c = crc ^ {b, 24'h000000};
		for (int i = 0; i < 8; i++) begin
			c = c[31] ? ({c[30:0], 1'b0} ^ poly) : {c[30:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// File: rtl/core/crc32_two_mode_byte_stream_core.sv
// ----------------------------------------------------------------------------
// CRC-32 two-mode byte stream core
// Folds one byte per word into a CRC register; emits the finished CRC on the
// last byte of each frame, reflected (Ethernet) or plain (BZIP2).
// ----------------------------------------------------------------------------
// The input register holds each accepted byte; the result register holds the finished CRC.
// Throughput: one byte per cycle; the input register and the result register
// decouple the two channels, so only a stalled result blocks a last byte.
// Reset: CRC register all ones, Ethernet mode on, polynomial 0x04C11DB7.
module crc32_two_mode_byte_stream_core
	import crc32tm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [31:0]          crc_value,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	logic  eth_mode_q;
	crc_t  poly_q;
	crc_t  crc_q;
	logic  valid_s1;
	byte_t byte_s1;
	logic  last_s1;
	logic  out_valid_q;
	crc_t  crc_value_q;

	logic  adv;
	logic  in_take;
	byte_t fold_in;
	crc_t  crc_next;
	crc_t  crc_fin;

	assign adv      = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;
	assign fold_in  = eth_mode_q ? flip8(byte_s1) : byte_s1;
	assign crc_next = fold8(crc_q, fold_in, poly_q);
	assign crc_fin  = eth_mode_q ? flip32(~crc_next) : ~crc_next;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign crc_value = crc_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eth_mode_q <= 1'b1;
			poly_q     <= DEFAULT_POLY;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ETH_MODE: eth_mode_q <= cfg_data[0];
				CFG_POLY:     poly_q     <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_PRESET;
		end else if (adv) begin
			crc_q <= last_s1 ? CRC_PRESET : crc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			crc_value_q <= crc_fin;
		end
	end

endmodule

// File: rtl/core/crc32tm_checker.sv
// ----------------------------------------------------------------------------
// CRC-32 two-mode port checker
// Watches the core's ports for result ordering and stall behavior.
// ----------------------------------------------------------------------------
`include "crc32_two_mode_byte_stream_core_assert.svh"

module crc32tm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last_byte,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] crc_value
);

	`CRC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(crc_value))
	`CRC_ASSERT_NOW(a_rise_after_last, $rose(out_valid), $past(in_valid && !in_stall && last_byte, 2))
	`CRC_ASSERT_NOW(a_no_stall_when_empty, !out_valid, !in_stall)

endmodule

bind crc32_two_mode_byte_stream_core crc32tm_checker u_crc32tm_checker (.*);
